>>> rtl/core/fetl_pkg.sv
// Package for the file extension type lookup block.
// Holds sizes, codes, shared structs and the character folding functions.
// No dependencies.
package fetl_pkg;

   localparam int TableEntries = 32;
   localparam int ExtChars     = 8;
   localparam int CharW        = 8;
   localparam int ExtW         = 64;
   localparam int LenW         = 4;
   localparam int TypeW        = 8;
   localparam int IdxW         = $clog2(TableEntries);
   localparam int CountW       = $clog2(TableEntries + 1);

   localparam logic [CharW-1:0] DotChar   = 8'h2E;
   localparam logic [CharW-1:0] UpperLo   = 8'h41;
   localparam logic [CharW-1:0] UpperHi   = 8'h5A;
   localparam logic [CharW-1:0] CaseShift = 8'h20;

   localparam logic ModeLoad   = 1'b0;
   localparam logic ModeName   = 1'b1;
   localparam logic KindLookup = 1'b0;
   localparam logic KindLoad   = 1'b1;
   localparam logic ErrNone    = 1'b0;
   localparam logic ErrFull    = 1'b1;

   // Search key presented to the table.
   typedef struct packed {
      logic [ExtW-1:0] ext;
      logic [LenW-1:0] len;
   } key_type;

   // Load command to the table.
   typedef struct packed {
      logic             load;
      logic [TypeW-1:0] type_id;
   } load_type;

   // Table answer for the key presented.
   typedef struct packed {
      logic             hit;
      logic [TypeW-1:0] type_id;
      logic             full;
   } match_type;

   // Fold 'A'..'Z' to lower case, leave every other byte.
   function automatic logic [CharW-1:0] lower_char(input logic [CharW-1:0] c);
      logic [CharW-1:0] r;
      r = c;
      if (c >= UpperLo && c <= UpperHi) begin
         r = c + CaseShift;
      end
      return r;
   endfunction

   // Fold a packed extension and zero the bytes at and beyond len.
   function automatic logic [ExtW-1:0] lower_ext(input logic [ExtW-1:0] v,
                                                 input logic [LenW-1:0] len);
      logic [ExtW-1:0] r;
      r = '0;
      for (int i = 0; i < ExtChars; i++) begin
         if (LenW'(i) < len) begin
            r[i*CharW +: CharW] = lower_char(v[i*CharW +: CharW]);
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/core/fetl_table.sv
// Extension table: entry storage, parallel compare of all entries, load write.
// Depends on fetl_pkg.
module fetl_table (
   input  logic               clock,
   input  logic               reset,
   input  fetl_pkg::key_type  key,
   input  fetl_pkg::load_type load_cmd,
   output fetl_pkg::match_type match
);

   logic [fetl_pkg::ExtW-1:0]  entry_ext_ff  [fetl_pkg::TableEntries];
   logic [fetl_pkg::LenW-1:0]  entry_len_ff  [fetl_pkg::TableEntries];
   logic [fetl_pkg::TypeW-1:0] entry_type_ff [fetl_pkg::TableEntries];
   logic [fetl_pkg::TableEntries-1:0] entry_valid_ff, entry_valid_in;
   logic [fetl_pkg::CountW-1:0] used_ff, used_in;

   logic [fetl_pkg::TableEntries-1:0] hit_vec;
   logic [fetl_pkg::IdxW-1:0]         hit_idx;
   logic                              any_hit;
   logic                              full;
   logic                              do_append;
   logic [fetl_pkg::IdxW-1:0]         wr_idx;

   // Compare every entry at once; lowest index wins.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < fetl_pkg::TableEntries; i++) begin
         hit_vec[i] = entry_valid_ff[i] && (entry_len_ff[i] == key.len) &&
                      (entry_ext_ff[i] == key.ext);
      end
      for (int i = fetl_pkg::TableEntries - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            hit_idx = fetl_pkg::IdxW'(i);
         end
      end
   end

   assign any_hit = |hit_vec;
   assign full    = (used_ff == fetl_pkg::CountW'(fetl_pkg::TableEntries));

   assign match.hit     = any_hit;
   assign match.type_id = entry_type_ff[hit_idx];
   assign match.full    = full;

   // Append only a new extension, and only while slots remain.
   assign do_append = load_cmd.load && !any_hit && !full;
   assign wr_idx    = used_ff[fetl_pkg::IdxW-1:0];

   always_comb begin
      entry_valid_in = entry_valid_ff;
      used_in        = used_ff;
      if (do_append) begin
         entry_valid_in[wr_idx] = 1'b1;
         used_in                = used_ff + fetl_pkg::CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         used_ff        <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         used_ff        <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_cmd.load && any_hit) begin
         entry_type_ff[hit_idx] <= load_cmd.type_id;
      end else if (do_append) begin
         entry_ext_ff[wr_idx]  <= key.ext;
         entry_len_ff[wr_idx]  <= key.len;
         entry_type_ff[wr_idx] <= load_cmd.type_id;
      end
   end

endmodule

>>> rtl/core/file_extension_type_lookup_top.sv
// Top level of the file extension type lookup block.
// Depends on fetl_pkg and fetl_table.
//
// Usage: the block takes one transaction in every clock cycle and never raises
// busy. A load transaction (req_mode 0) stores a lower-cased extension with its
// type id and always answers with an acknowledgement (rsp_kind 1, rsp_error 1
// when the extension is new and all 32 slots are taken). A name transaction
// (req_mode 1) carries one character of a file name; only the one marked by
// req_last_char answers, with the type id of the text after the last dot, or
// rsp_found 0 when there is no dot, the extension is empty or longer than 8
// characters, or no entry matches. Each response appears on rsp_* for exactly
// one cycle, marked by rsp_valid, after its transaction passes the request
// register and the response register; the receiver cannot stall it, so it must
// be ready every cycle. There is one register stage for the request and one
// compare stage that matches the key against all table entries in parallel.
module file_extension_type_lookup_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [63:0] req_ext_packed,
   input  logic [3:0]  req_ext_len,
   input  logic [7:0]  req_type_id,
   input  logic [7:0]  req_char_in,
   input  logic        req_last_char,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic        rsp_found,
   output logic [7:0]  rsp_result_type,
   output logic        rsp_error
);

   // Request register.
   logic                        item_vld_ff;
   logic                        mode_ff;
   logic [fetl_pkg::ExtW-1:0]   ext_ff;
   logic [fetl_pkg::LenW-1:0]   len_ff;
   logic [fetl_pkg::TypeW-1:0]  type_ff;
   logic [fetl_pkg::CharW-1:0]  char_ff;
   logic                        last_ff;

   // Extension capture for the name in flight.
   logic [fetl_pkg::ExtW-1:0]   cap_chars_ff, cap_chars_in;
   logic [fetl_pkg::LenW-1:0]   cap_len_ff, cap_len_in;
   logic                        cap_ovf_ff, cap_ovf_in;
   logic                        dot_ff, dot_in;

   // Capture after the current character, before the end-of-name clear.
   logic [fetl_pkg::ExtW-1:0]   upd_chars;
   logic [fetl_pkg::LenW-1:0]   upd_len;
   logic                        upd_ovf;
   logic                        upd_dot;

   logic [fetl_pkg::CharW-1:0]  low_char;
   logic [fetl_pkg::LenW-1:0]   load_len;
   logic                        is_load;
   logic                        is_name;
   logic                        lookup_ok;

   fetl_pkg::key_type           key;
   fetl_pkg::load_type          load_cmd;
   fetl_pkg::match_type         match;

   // Response register.
   logic                        rsp_valid_ff;
   logic                        rsp_kind_ff;
   logic                        rsp_found_ff;
   logic [fetl_pkg::TypeW-1:0]  rsp_type_ff;
   logic                        rsp_error_ff;

   // Every cycle is open for a new transaction.
   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= start && !busy;
      end
   end

   // Hold the request payload; no reset needed.
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         mode_ff <= req_mode;
         ext_ff  <= req_ext_packed;
         len_ff  <= req_ext_len;
         type_ff <= req_type_id;
         char_ff <= req_char_in;
         last_ff <= req_last_char;
      end
   end

   assign is_load = item_vld_ff && (mode_ff == fetl_pkg::ModeLoad);
   assign is_name = item_vld_ff && (mode_ff == fetl_pkg::ModeName);

   // Saturate the load length to the widest extension.
   assign load_len = (len_ff > fetl_pkg::LenW'(fetl_pkg::ExtChars)) ?
                     fetl_pkg::LenW'(fetl_pkg::ExtChars) : len_ff;

   assign low_char = fetl_pkg::lower_char(char_ff);

   // Advance the capture: a dot restarts it, other bytes append until full.
   always_comb begin
      upd_chars = cap_chars_ff;
      upd_len   = cap_len_ff;
      upd_ovf   = cap_ovf_ff;
      upd_dot   = dot_ff;
      if (low_char == fetl_pkg::DotChar) begin
         upd_chars = '0;
         upd_len   = '0;
         upd_ovf   = 1'b0;
         upd_dot   = 1'b1;
      end else if (cap_len_ff < fetl_pkg::LenW'(fetl_pkg::ExtChars)) begin
         for (int i = 0; i < fetl_pkg::ExtChars; i++) begin
            if (cap_len_ff == fetl_pkg::LenW'(i)) begin
               upd_chars[i*fetl_pkg::CharW +: fetl_pkg::CharW] = low_char;
            end
         end
         upd_len = cap_len_ff + fetl_pkg::LenW'(1);
      end else begin
         upd_ovf = 1'b1;
      end
   end

   assign lookup_ok = upd_dot && (upd_len != '0) && !upd_ovf;

   // Drop the capture at the end of each name.
   always_comb begin
      cap_chars_in = cap_chars_ff;
      cap_len_in   = cap_len_ff;
      cap_ovf_in   = cap_ovf_ff;
      dot_in       = dot_ff;
      if (is_name) begin
         if (last_ff) begin
            cap_chars_in = '0;
            cap_len_in   = '0;
            cap_ovf_in   = 1'b0;
            dot_in       = 1'b0;
         end else begin
            cap_chars_in = upd_chars;
            cap_len_in   = upd_len;
            cap_ovf_in   = upd_ovf;
            dot_in       = upd_dot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_chars_ff <= '0;
         cap_len_ff   <= '0;
         cap_ovf_ff   <= 1'b0;
         dot_ff       <= 1'b0;
      end else begin
         cap_chars_ff <= cap_chars_in;
         cap_len_ff   <= cap_len_in;
         cap_ovf_ff   <= cap_ovf_in;
         dot_ff       <= dot_in;
      end
   end

   // Present the load extension or the finished capture to the table.
   always_comb begin
      if (mode_ff == fetl_pkg::ModeLoad) begin
         key.ext = fetl_pkg::lower_ext(ext_ff, load_len);
         key.len = load_len;
      end else begin
         key.ext = upd_chars;
         key.len = upd_len;
      end
   end

   assign load_cmd.load    = is_load;
   assign load_cmd.type_id = type_ff;

   fetl_table u_table (
      .clock    (clock),
      .reset    (reset),
      .key      (key),
      .load_cmd (load_cmd),
      .match    (match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= is_load || (is_name && last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (is_load) begin
         rsp_kind_ff  <= fetl_pkg::KindLoad;
         rsp_found_ff <= 1'b0;
         rsp_type_ff  <= '0;
         rsp_error_ff <= (!match.hit && match.full) ? fetl_pkg::ErrFull : fetl_pkg::ErrNone;
      end else begin
         rsp_kind_ff  <= fetl_pkg::KindLookup;
         rsp_found_ff <= lookup_ok && match.hit;
         rsp_type_ff  <= (lookup_ok && match.hit) ? match.type_id : '0;
         rsp_error_ff <= fetl_pkg::ErrNone;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_result_type = rsp_type_ff;
   assign rsp_error       = rsp_error_ff;

`ifndef ASSERT_OFF
   a_rsp_follows_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(item_vld_ff))
      else $error("response without a transaction two cycles earlier");

   a_load_ack_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == fetl_pkg::KindLoad) |->
      (!rsp_found && rsp_result_type == '0))
      else $error("load acknowledgement carries lookup data");

   a_lookup_no_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == fetl_pkg::KindLookup) |-> (rsp_error == fetl_pkg::ErrNone))
      else $error("lookup response flags an error");

   a_capture_cleared: assert property (@(posedge clock) disable iff (reset)
      (is_name && last_ff) |=> (cap_len_ff == '0 && !dot_ff && !cap_ovf_ff))
      else $error("capture not cleared after end of name");
`endif

endmodule

>>> bench/file_extension_type_lookup_top_tb.sv
// Self-checking bench for file_extension_type_lookup_top: table loads and streamed names.
// Depends on fetl_pkg and the block's RTL; holds its own predictor inside a scoreboard class.
module file_extension_type_lookup_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomItems = 2000;
   localparam int PoolSize    = 40;   // more extensions than slots, so the table fills up
   localparam int QuietLimit  = 1000; // cycles without any transaction or response before giving up
   localparam int DrainCycles = 6;    // extra wait once every response has arrived

   // One input transaction, field for field as the request ports carry it.
   typedef struct packed {
      logic                       mode;
      logic [fetl_pkg::ExtW-1:0]  ext_packed;
      logic [fetl_pkg::LenW-1:0]  ext_len;
      logic [fetl_pkg::TypeW-1:0] type_id;
      logic [fetl_pkg::CharW-1:0] char_in;
      logic                       last_char;
   } request_type;

   // One response as it appears on the rsp_ ports.
   typedef struct packed {
      logic                       kind;
      logic                       found;
      logic [fetl_pkg::TypeW-1:0] result_type;
      logic                       error;
   } answer_type;

   // Scoreboard: mirrors the extension table and the name capture, and queues
   // the answer that each accepted transaction must produce.
   class ext_checker_type;
      logic [fetl_pkg::ExtW-1:0]  stored_ext  [fetl_pkg::TableEntries];
      logic [fetl_pkg::LenW-1:0]  stored_len  [fetl_pkg::TableEntries];
      logic [fetl_pkg::TypeW-1:0] stored_type [fetl_pkg::TableEntries];
      bit                         stored_valid[fetl_pkg::TableEntries];
      int                         slots_used;
      logic [fetl_pkg::ExtW-1:0]  tail_chars;   // text after the most recent dot
      int                         tail_len;
      bit                         tail_overflow;
      bit                         dot_found;
      answer_type                 answers_due[$];
      int                         failures;
      int                         loads;
      int                         refusals;
      int                         lookups;
      int                         hits;

      function new();
         foreach (stored_valid[i]) stored_valid[i] = 1'b0;
         slots_used    = 0;
         tail_chars    = '0;
         tail_len      = 0;
         tail_overflow = 1'b0;
         dot_found     = 1'b0;
      endfunction

      function logic [fetl_pkg::CharW-1:0] fold_char(logic [fetl_pkg::CharW-1:0] c);
         if (c >= fetl_pkg::UpperLo && c <= fetl_pkg::UpperHi) return c | fetl_pkg::CaseShift;
         return c;
      endfunction

      function int find_entry(logic [fetl_pkg::ExtW-1:0] key, logic [fetl_pkg::LenW-1:0] n);
         for (int i = 0; i < fetl_pkg::TableEntries; i++) begin
            if (stored_valid[i] && stored_len[i] == n && stored_ext[i] == key) return i;
         end
         return -1;
      endfunction

      function void clear_tail();
         tail_chars    = '0;
         tail_len      = 0;
         tail_overflow = 1'b0;
      endfunction

      // Advance the mirror by one accepted transaction; queue its answer, if any.
      function void take_request(request_type r);
         answer_type                 a;
         logic [fetl_pkg::LenW-1:0]  n;
         logic [fetl_pkg::ExtW-1:0]  key;
         logic [fetl_pkg::CharW-1:0] c;
         int                         slot;
         a = '0;
         if (r.mode == fetl_pkg::ModeLoad) begin
            n   = (r.ext_len > fetl_pkg::ExtChars) ? fetl_pkg::LenW'(fetl_pkg::ExtChars)
                                                   : r.ext_len;
            key = '0;
            for (int i = 0; i < fetl_pkg::ExtChars; i++) begin
               if (i < n) begin
                  key[i*fetl_pkg::CharW +: fetl_pkg::CharW] =
                     fold_char(r.ext_packed[i*fetl_pkg::CharW +: fetl_pkg::CharW]);
               end
            end
            slot = find_entry(key, n);
            if (slot >= 0) begin
               stored_type[slot] = r.type_id;
            end else if (slots_used < fetl_pkg::TableEntries) begin
               stored_ext[slots_used]   = key;
               stored_len[slots_used]   = n;
               stored_type[slots_used]  = r.type_id;
               stored_valid[slots_used] = 1'b1;
               slots_used++;
            end else begin
               a.error = fetl_pkg::ErrFull;
               refusals++;
            end
            a.kind = fetl_pkg::KindLoad;
            loads++;
            answers_due = {answers_due, a};
         end else begin
            c = fold_char(r.char_in);
            if (c == fetl_pkg::DotChar) begin
               clear_tail();
               dot_found = 1'b1;
            end else if (tail_len < fetl_pkg::ExtChars) begin
               tail_chars[tail_len*fetl_pkg::CharW +: fetl_pkg::CharW] = c;
               tail_len++;
            end else begin
               tail_overflow = 1'b1;
            end
            if (r.last_char) begin
               a.kind = fetl_pkg::KindLookup;
               if (dot_found && tail_len != 0 && !tail_overflow) begin
                  slot = find_entry(tail_chars, fetl_pkg::LenW'(tail_len));
                  if (slot >= 0) begin
                     a.found       = 1'b1;
                     a.result_type = stored_type[slot];
                     hits++;
                  end
               end
               clear_tail();
               dot_found = 1'b0;
               lookups++;
               answers_due = {answers_due, a};
            end
         end
      endfunction

      function void compare_field(string field, logic [fetl_pkg::TypeW-1:0] want,
                                  logic [fetl_pkg::TypeW-1:0] seen);
         if (want !== seen) begin
            $error("%s: expected %0h, got %0h", field, want, seen);
            failures++;
         end
      endfunction

      // Check one response against the oldest queued answer.
      function void check_response(answer_type got);
         answer_type want;
         if (answers_due.size() == 0) begin
            $error("response with nothing outstanding: kind %0h found %0h type %0h error %0h",
                   got.kind, got.found, got.result_type, got.error);
            failures++;
            return;
         end
         want = answers_due.pop_front();
         compare_field("rsp_kind", fetl_pkg::TypeW'(want.kind), fetl_pkg::TypeW'(got.kind));
         compare_field("rsp_found", fetl_pkg::TypeW'(want.found), fetl_pkg::TypeW'(got.found));
         compare_field("rsp_result_type", want.result_type, got.result_type);
         compare_field("rsp_error", fetl_pkg::TypeW'(want.error), fetl_pkg::TypeW'(got.error));
      endfunction

      function int pending();
         return answers_due.size();
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_mode = fetl_pkg::ModeLoad;
   logic [63:0]      req_ext_packed = '0;
   logic [3:0]       req_ext_len = '0;
   logic [7:0]       req_type_id = '0;
   logic [7:0]       req_char_in = '0;
   logic             req_last_char = 1'b0;
   logic             rsp_valid;
   logic             rsp_kind;
   logic             rsp_found;
   logic [7:0]       rsp_result_type;
   logic             rsp_error;

   ext_checker_type            book = new();
   int                         items_sent = 0;
   int                         idle_pct = 0;
   int                         quiet_cycles = 0;
   logic [fetl_pkg::CharW-1:0] name_buf[$];
   logic [fetl_pkg::ExtW-1:0]  pool_ext[PoolSize];
   int                         pool_len[PoolSize];

   file_extension_type_lookup_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_ext_packed (req_ext_packed),
      .req_ext_len    (req_ext_len),
      .req_type_id    (req_type_id),
      .req_char_in    (req_char_in),
      .req_last_char  (req_last_char),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_found      (rsp_found),
      .rsp_result_type(rsp_result_type),
      .rsp_error      (rsp_error)
   );

   // 2 ns clock: high for one, low for one.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Fully random transaction; callers overwrite the fields that matter, so the
   // fields the block should ignore still carry noise.
   function automatic request_type random_request();
      request_type r;
      r.mode       = 1'($urandom_range(1));
      r.ext_packed = {$urandom, $urandom};
      r.ext_len    = fetl_pkg::LenW'($urandom_range(15));
      r.type_id    = fetl_pkg::TypeW'($urandom_range(255));
      r.char_in    = fetl_pkg::CharW'($urandom_range(255));
      r.last_char  = 1'($urandom_range(1));
      return r;
   endfunction

   // Mostly lower-case letters and digits, now and then any byte that is
   // neither a dot nor an upper-case letter (the pool holds folded text).
   function automatic logic [fetl_pkg::CharW-1:0] pick_ext_char();
      int                         roll;
      logic [fetl_pkg::CharW-1:0] c;
      roll = $urandom_range(99);
      if (roll < 70) return fetl_pkg::CharW'(8'h61 + $urandom_range(25));
      if (roll < 85) return fetl_pkg::CharW'(8'h30 + $urandom_range(9));
      do begin
         c = fetl_pkg::CharW'($urandom_range(255));
      end while (c == fetl_pkg::DotChar || (c >= fetl_pkg::UpperLo && c <= fetl_pkg::UpperHi));
      return c;
   endfunction

   function automatic logic [fetl_pkg::CharW-1:0] non_dot_byte();
      logic [fetl_pkg::CharW-1:0] c;
      do begin
         c = fetl_pkg::CharW'($urandom_range(255));
      end while (c == fetl_pkg::DotChar);
      return c;
   endfunction

   // Raise a lower-case letter to upper case half the time.
   function automatic logic [fetl_pkg::CharW-1:0] vary_case(logic [fetl_pkg::CharW-1:0] c);
      if (c >= 8'h61 && c <= 8'h7A && $urandom_range(1) == 1) return c - fetl_pkg::CaseShift;
      return c;
   endfunction

   // Append one character to the name being built.
   function automatic void add_char(input logic [fetl_pkg::CharW-1:0] c);
      name_buf = {name_buf, c};
   endfunction

   // Present one transaction at the falling edge, after an optional idle gap,
   // and hold it until a rising edge sees start high and busy low.
   task automatic send_item(input request_type r);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start          <= 1'b1;
      req_mode       <= r.mode;
      req_ext_packed <= r.ext_packed;
      req_ext_len    <= r.ext_len;
      req_type_id    <= r.type_id;
      req_char_in    <= r.char_in;
      req_last_char  <= r.last_char;
      @(posedge clock);
      while (busy) @(posedge clock);
      book.take_request(r);
      items_sent++;
   endtask

   task automatic send_load(input logic [fetl_pkg::ExtW-1:0] ext,
                            input logic [fetl_pkg::LenW-1:0] n,
                            input logic [fetl_pkg::TypeW-1:0] tid);
      request_type r;
      r            = random_request();
      r.mode       = fetl_pkg::ModeLoad;
      r.ext_packed = ext;
      r.ext_len    = n;
      r.type_id    = tid;
      send_item(r);
   endtask

   // Stream name_buf one character per transaction, marking the final one.
   task automatic send_name();
      request_type r;
      foreach (name_buf[i]) begin
         r           = random_request();
         r.mode      = fetl_pkg::ModeName;
         r.char_in   = name_buf[i];
         r.last_char = (i == name_buf.size() - 1);
         send_item(r);
      end
      name_buf.delete();
   endtask

   // Load a pool extension in mixed case with junk past its length; a full
   // eight-character one sometimes comes with an oversized length.
   task automatic load_from_pool(input int k);
      logic [fetl_pkg::ExtW-1:0]  ext;
      logic [fetl_pkg::LenW-1:0]  n;
      for (int i = 0; i < fetl_pkg::ExtChars; i++) begin
         ext[i*fetl_pkg::CharW +: fetl_pkg::CharW] =
            (i < pool_len[k]) ? vary_case(pool_ext[k][i*fetl_pkg::CharW +: fetl_pkg::CharW])
                              : fetl_pkg::CharW'($urandom_range(255));
      end
      n = fetl_pkg::LenW'(pool_len[k]);
      if (pool_len[k] == fetl_pkg::ExtChars && $urandom_range(1) == 1) begin
         n = fetl_pkg::LenW'($urandom_range(9, 15));
      end
      send_load(ext, n, fetl_pkg::TypeW'($urandom_range(255)));
   endtask

   // Well-formed name: random stem (dots allowed), a dot, then a pool extension.
   task automatic name_from_pool(input int k);
      repeat ($urandom_range(5)) begin
         add_char(($urandom_range(99) < 15) ? fetl_pkg::DotChar : non_dot_byte());
      end
      add_char(fetl_pkg::DotChar);
      for (int i = 0; i < pool_len[k]; i++) begin
         add_char(vary_case(pool_ext[k][i*fetl_pkg::CharW +: fetl_pkg::CharW]));
      end
      send_name();
   endtask

   // Broken names: no dot, trailing dot, overlong extension, or plain noise.
   task automatic name_noise();
      case ($urandom_range(3))
         0: begin
            repeat ($urandom_range(1, 7)) add_char(non_dot_byte());
         end
         1: begin
            repeat ($urandom_range(4)) add_char(non_dot_byte());
            add_char(fetl_pkg::DotChar);
         end
         2: begin
            add_char(fetl_pkg::DotChar);
            repeat ($urandom_range(9, 12)) add_char(non_dot_byte());
         end
         default: begin
            repeat ($urandom_range(1, 12)) begin
               add_char(($urandom_range(99) < 25) ? fetl_pkg::DotChar
                                                  : fetl_pkg::CharW'($urandom_range(255)));
            end
         end
      endcase
      send_name();
   endtask

   // Check every response in the cycle its strobe is high.
   always @(posedge clock) begin
      answer_type got;
      if (!reset && rsp_valid) begin
         got.kind        = rsp_kind;
         got.found       = rsp_found;
         got.result_type = rsp_result_type;
         got.error       = rsp_error;
         book.check_response(got);
      end
   end

   // Watchdog: drop the run once nothing has moved for QuietLimit cycles.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QuietLimit) begin
            $error("no transaction for %0d cycles, %0d responses outstanding",
                   QuietLimit, book.pending());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      int phase_end;
      int roll;

      // Build the extension pool: lengths 1..8, folded text, zero past the end.
      for (int k = 0; k < PoolSize; k++) begin
         pool_len[k] = $urandom_range(1, fetl_pkg::ExtChars);
         pool_ext[k] = '0;
         for (int i = 0; i < pool_len[k]; i++) begin
            pool_ext[k][i*fetl_pkg::CharW +: fetl_pkg::CharW] = pick_ext_char();
         end
      end

      // Hold reset, then release it at a falling edge.
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed opening. Mixed-case load with junk beyond its length.
      send_load(64'hA5A5_A5A5_A554_7854, 4'd3, 8'hFF);
      // Length above eight saturates; 0xFF bytes are not letters.
      send_load(64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 8'h00);
      // Empty extension: stored, yet no lookup may ever hit it.
      send_load(64'h0, 4'h0, 8'h5A);
      // Same extension in lower case: overwrite the type id only.
      send_load(64'h0000_0000_0074_7874, 4'd3, 8'h01);
      // Upper-case name that must find the overwritten entry.
      name_buf = {8'h61, fetl_pkg::DotChar, 8'h54, 8'h58, 8'h54};
      send_name();
      // Single zero byte, no dot at all.
      name_buf = {8'h00};
      send_name();
      // Name ending in a dot, then a lone dot: empty extension both times.
      name_buf = {8'h78, fetl_pkg::DotChar};
      send_name();
      name_buf = {fetl_pkg::DotChar};
      send_name();
      // Nine 0xFF characters after the dot: one too many, so no match.
      add_char(fetl_pkg::DotChar);
      repeat (9) add_char(8'hFF);
      send_name();

      // Random part in three stretches: light sender idling, heavy, none.
      for (int p = 0; p < 3; p++) begin
         idle_pct  = (p == 0) ? 13 : (p == 1) ? 76 : 0;
         phase_end = items_sent + RandomItems / 3;
         while (items_sent < phase_end) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
               load_from_pool($urandom_range(PoolSize - 1));
            end else if (roll < 25) begin
               send_load({$urandom, $urandom}, fetl_pkg::LenW'($urandom_range(15)),
                         fetl_pkg::TypeW'($urandom_range(255)));
            end else if (roll < 85) begin
               name_from_pool($urandom_range(PoolSize - 1));
            end else begin
               name_noise();
            end
         end
      end

      // Stop offering transactions and let the last responses come out.
      @(negedge clock);
      start <= 1'b0;
      while (book.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Ran %0d transactions: %0d loads, %0d refused with the table full.",
               items_sent, book.loads, book.refusals);
      $display("Answered %0d name lookups, %0d of them hits, under three idling patterns.",
               book.lookups, book.hits);
      if (book.failures == 0 && book.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         if (book.pending() != 0) $error("%0d responses never arrived", book.pending());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> file_extension_type_lookup_top.f
rtl/core/fetl_pkg.sv
rtl/core/fetl_table.sv
rtl/core/file_extension_type_lookup_top.sv
bench/file_extension_type_lookup_top_tb.sv
